// ===== rtl/core/bzpwm_pkg.sv =====
// Package for the buzzer pulse-width generator.
// Operation codes, defaults and fixed constants shared by the core and its checker.
// No dependencies.
package bzpwm_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_BEEP  = 3'd3,
    OP_CLICK = 3'd4
  } op_t;

  // Register map (word index)
  localparam logic REG_VOLUME = 1'b0;

  // Defaults for the top-level parameters
  localparam int DEF_PERIOD_MICROS = 250;
  localparam int DEF_SYS_TICK_HZ   = 100;

  // Field widths
  localparam int OP_W       = 3;
  localparam int DUTY_IN_W  = 8;
  localparam int DUR_W      = 16;
  localparam int DUTY_W     = 7;
  localparam int PHASE_W    = 8;
  localparam int STOP_W     = 13;

  // Fixed values
  localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd100;
  localparam logic [DUTY_W-1:0] VOLUME_RESET  = 7'd100;
  localparam logic [DUR_W-1:0]  BEEP_MS       = 16'd250;
  localparam logic [DUR_W-1:0]  CLICK_MS      = 16'd25;
  localparam logic [STOP_W-1:0] STOP_LEFT_MAX = 13'd8191;

endpackage

// ===== rtl/core/buzzer_pwm_with_timeout_unit.sv =====
// Buzzer pulse-width generator with a timed stop: top level.
// Holds the tone state, the volume register and the result register.
// Depends on bzpwm_pkg.
//
// Channel  | Dir | Signals                         | Contents
// ---------+-----+---------------------------------+------------------------------------
// s_*      | in  | s_tvalid s_tready s_tdata s_tuser| requests: duty, duration, sys tick; op
// m_*      | out | m_tvalid m_tready m_tdata       | results: pin level, active
// APB      | in  | psel penable pwrite paddr ...   | buzzer_volume at byte address 0
//
// One request per clock while the result register is free or draining: the
// request is decoded and the tone state and the result register are both written at the accepting edge.
// The result is valid in the cycle after the request is accepted.
// The only limit on rate is the single result register: a request is taken
// whenever the result register is empty or being drained in the same cycle.
// Reset (rst, synchronous) clears the tone state, the result valid and sets
// the volume to 100; no clearing pass is needed.
module buzzer_pwm_with_timeout_unit #(
  parameter int PERIOD_MICROS = bzpwm_pkg::DEF_PERIOD_MICROS,
  parameter int SYS_TICK_HZ   = bzpwm_pkg::DEF_SYS_TICK_HZ
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [7:0] duty_percent, [23:8] duration_ms, [24] sys_tick
  input  logic [2:0]  s_tuser,   // [2:0] operation
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] pin_level, [1] active
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DUTY_W  = bzpwm_pkg::DUTY_W;
  localparam int PHASE_W = bzpwm_pkg::PHASE_W;
  localparam int STOP_W  = bzpwm_pkg::STOP_W;
  localparam int DUR_W   = bzpwm_pkg::DUR_W;

  // High time = PERIOD*duty/100 as duty * (PERIOD * ceil(2^21/100)) >> 21.
  // Exact while PERIOD*duty stays below 2^21/48.
  localparam int               ON_SHIFT = 21;
  localparam longint unsigned  ON_RECIP = ((64'd1 << ON_SHIFT) + 64'd99) / 64'd100;
  localparam int               ON_MUL_W = 23;
  localparam logic [ON_MUL_W-1:0] ON_MUL = ON_MUL_W'(64'(PERIOD_MICROS) * ON_RECIP);
  localparam int               ON_PROD_W = DUTY_W + ON_MUL_W;

  // Stop ticks = duration*HZ/1000 as duration * (HZ * ceil(2^33/1000)) >> 33.
  // Exact below the saturation point; above it the estimate never undershoots.
  localparam int               TK_SHIFT = 33;
  localparam longint unsigned  TK_RECIP = ((64'd1 << TK_SHIFT) + 64'd999) / 64'd1000;
  localparam int               TK_MUL_W = 34;
  localparam logic [TK_MUL_W-1:0] TK_MUL = TK_MUL_W'(64'(SYS_TICK_HZ) * TK_RECIP);
  localparam int               TK_PROD_W = DUR_W + TK_MUL_W;
  localparam int               TK_RAW_W  = TK_PROD_W - TK_SHIFT;

  localparam logic [PHASE_W-1:0] PERIOD_VAL = PHASE_W'(PERIOD_MICROS);

  // Tone state
  logic               is_active, is_active_next;
  logic               high_phase, high_phase_next;
  logic               toggling, toggling_next;
  logic [PHASE_W-1:0] high_time, high_time_next;
  logic [PHASE_W-1:0] low_time, low_time_next;
  logic [PHASE_W-1:0] phase_left, phase_left_next;
  logic [STOP_W-1:0]  stop_left, stop_left_next;
  logic               stop_armed, stop_armed_next;
  logic [DUTY_W-1:0]  volume;

  // Request fields
  logic [2:0]               op;
  logic [bzpwm_pkg::DUTY_IN_W-1:0] duty_in;
  logic [DUR_W-1:0]         dur_in;
  logic                     sys_in;
  logic                     accept;

  // Start arithmetic
  logic [DUTY_W-1:0]    duty_src, duty_sat;
  logic [DUR_W-1:0]     dur_sel;
  logic [ON_PROD_W-1:0] on_prod;
  logic [PHASE_W-1:0]   on_raw, on_time;
  logic [TK_PROD_W-1:0] tk_prod;
  logic [TK_RAW_W-1:0]  tk_raw;
  logic [STOP_W-1:0]    ticks;

  assign op      = s_tuser;
  assign duty_in = s_tdata[7:0];
  assign dur_in  = s_tdata[23:8];
  assign sys_in  = s_tdata[24];
  assign accept  = s_tvalid && s_tready;

  // Take a request whenever the result register is free or draining
  assign s_tready = !m_tvalid || m_tready;

  // Select duty and duration for the start-like operations
  always_comb begin
    if (op == bzpwm_pkg::OP_START) begin
      duty_src = (duty_in > 8'(bzpwm_pkg::DUTY_MAX)) ? bzpwm_pkg::DUTY_MAX : duty_in[DUTY_W-1:0];
      dur_sel  = dur_in;
    end else begin
      duty_src = volume;
      dur_sel  = (op == bzpwm_pkg::OP_BEEP) ? bzpwm_pkg::BEEP_MS : bzpwm_pkg::CLICK_MS;
    end
    duty_sat = (duty_src > bzpwm_pkg::DUTY_MAX) ? bzpwm_pkg::DUTY_MAX : duty_src;
  end

  // High time from the duty, at least one microsecond
  assign on_prod = ON_PROD_W'(duty_sat) * ON_PROD_W'(ON_MUL);
  assign on_raw  = on_prod[ON_SHIFT +: PHASE_W];
  assign on_time = (on_raw == '0) ? PHASE_W'(1) : on_raw;

  // Stop ticks from the duration, at least one, saturated to the counter
  assign tk_prod = TK_PROD_W'(dur_sel) * TK_PROD_W'(TK_MUL);
  assign tk_raw  = tk_prod[TK_SHIFT +: TK_RAW_W];
  always_comb begin
    if (tk_raw > TK_RAW_W'(bzpwm_pkg::STOP_LEFT_MAX)) begin
      ticks = bzpwm_pkg::STOP_LEFT_MAX;
    end else if (tk_raw == '0) begin
      ticks = STOP_W'(1);
    end else begin
      ticks = tk_raw[STOP_W-1:0];
    end
  end

  // Next tone state for the accepted request
  always_comb begin
    logic halt;
    logic start;
    halt  = 1'b0;
    start = 1'b0;
    is_active_next  = is_active;
    high_phase_next = high_phase;
    toggling_next   = toggling;
    high_time_next  = high_time;
    low_time_next   = low_time;
    phase_left_next = phase_left;
    stop_left_next  = stop_left;
    stop_armed_next = stop_armed;

    unique case (op)
      bzpwm_pkg::OP_TICK: begin
        if (is_active) begin
          if (sys_in && stop_armed) begin
            if (stop_left <= STOP_W'(1)) begin
              halt = 1'b1;
            end else begin
              stop_left_next = stop_left - STOP_W'(1);
            end
          end
          if (!halt && toggling) begin
            // End the phase on a count of one (or zero) and swap halves
            if (phase_left <= PHASE_W'(1)) begin
              high_phase_next = !high_phase;
              phase_left_next = high_phase ? low_time : high_time;
            end else begin
              phase_left_next = phase_left - PHASE_W'(1);
            end
          end
        end
      end
      bzpwm_pkg::OP_START, bzpwm_pkg::OP_BEEP, bzpwm_pkg::OP_CLICK: begin
        if (duty_sat == '0) begin
          halt = 1'b1;
        end else begin
          start = 1'b1;
        end
      end
      bzpwm_pkg::OP_STOP: begin
        halt = 1'b1;
      end
      default: begin
      end
    endcase

    if (start) begin
      is_active_next  = 1'b1;
      high_phase_next = 1'b1;
      high_time_next  = on_time;
      low_time_next   = PERIOD_VAL - on_time;
      toggling_next   = (PERIOD_VAL != on_time);
      phase_left_next = on_time;
      if (dur_sel != '0) begin
        stop_left_next  = ticks;
        stop_armed_next = 1'b1;
      end else begin
        stop_left_next  = '0;
        stop_armed_next = 1'b0;
      end
    end
    if (halt) begin
      is_active_next  = 1'b0;
      high_phase_next = 1'b0;
      toggling_next   = 1'b0;
      high_time_next  = '0;
      low_time_next   = '0;
      phase_left_next = '0;
      stop_left_next  = '0;
      stop_armed_next = 1'b0;
    end
  end

  // Tone state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      is_active  <= 1'b0;
      high_phase <= 1'b0;
      toggling   <= 1'b0;
      high_time  <= '0;
      low_time   <= '0;
      phase_left <= '0;
      stop_left  <= '0;
      stop_armed <= 1'b0;
    end else if (accept) begin
      is_active  <= is_active_next;
      high_phase <= high_phase_next;
      toggling   <= toggling_next;
      high_time  <= high_time_next;
      low_time   <= low_time_next;
      phase_left <= phase_left_next;
      stop_left  <= stop_left_next;
      stop_armed <= stop_armed_next;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'b0, is_active_next, is_active_next && high_phase_next};
    end
  end

  // Volume register on the configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= bzpwm_pkg::VOLUME_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == bzpwm_pkg::REG_VOLUME) begin
      volume <= pwdata[DUTY_W-1:0];
    end
  end

  assign prdata = (paddr[2] == bzpwm_pkg::REG_VOLUME) ? {25'b0, volume} : 32'b0;

endmodule

// ===== rtl/core/bzpwm_checker.sv =====
// Port-level checker for the buzzer pulse-width generator, bound to the top level.
// Depends on bzpwm_pkg and buzzer_pwm_with_timeout_unit.
module bzpwm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [2:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Hold a stalled result steady
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Never drive the pin while the buzzer is idle
  a_pin_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
    else $error("pin high while inactive");

  // A stop request shows an idle result on the next cycle
  a_stop: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == bzpwm_pkg::OP_STOP |=> m_tvalid && !m_tdata[1])
    else $error("stop request left buzzer active");

  // Refuse requests while a result is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken over a stalled result");

  // Come out of reset with no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind buzzer_pwm_with_timeout_unit bzpwm_checker u_bzpwm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
